### hw/rtl/affine_2d_transform_matrix_unit_defines.svh
// Assertion macros shared by the affine transform unit.
`ifndef AFFINE_2D_TRANSFORM_MATRIX_UNIT_DEFINES_SVH
`define AFFINE_2D_TRANSFORM_MATRIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define AFF2D_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("aff2d assertion failed");
`define AFF2D_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("aff2d assertion failed");
`else
`define AFF2D_ASSERT(lbl, prop)
`define AFF2D_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/aff2d_pkg.sv
package aff2d_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // angles in radians, Q.32
    localparam logic signed [35:0] ANG_TWO_PI  = 36'sd26986075409;
    localparam logic signed [35:0] ANG_PI      = 36'sd13493037705;
    localparam logic signed [35:0] ANG_HALF_PI = 36'sd6746518852;
    // floor(2^24 / two pi): quotient estimate for the angle reduction
    localparam logic signed [22:0] TWO_PI_RECIP = 23'sd2670176;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [35:0] ATAN_Q32 [MAX_STAGES] = '{
        36'd3373259426, 36'd1991351318, 36'd1052175346, 36'd534100635,
        36'd268086715,  36'd134174062,  36'd67103403,   36'd33553749,
        36'd16777131,   36'd8388597,    36'd4194303,    36'd2097152,
        36'd1048576,    36'd524288,     36'd262144,     36'd131072,
        36'd65536,      36'd32768,      36'd16384,      36'd8192,
        36'd4096,       36'd2048,       36'd1024,       36'd512
    };

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [23:0] sx;
        logic [23:0] sy;
        logic        neg;
    } t_side;

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] res;
        if (v > 27'sd8388607) begin
            res = 24'h7fffff;
        end else if (v < -27'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        logic [31:0] res;
        if (v > 44'sd2147483647) begin
            res = 32'h7fffffff;
        end else if (v < -44'sd2147483648) begin
            res = 32'h80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/aff2d_cordic.sv
module aff2d_cordic #(
    parameter int STAGES = aff2d_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [35:0]   i_z,
    input  aff2d_pkg::t_side     i_side,
    output logic                 o_vld,
    output logic signed [33:0]   o_x,
    output logic signed [33:0]   o_y,
    output aff2d_pkg::t_side     o_side
);
    import aff2d_pkg::*;

    localparam int NS = (STAGES > MAX_STAGES) ? MAX_STAGES : ((STAGES < 1) ? 1 : STAGES);

    logic signed [33:0] r_x [NS];
    logic signed [33:0] r_y [NS];
    logic signed [35:0] r_z [NS];
    t_side              r_side [NS];
    logic [NS-1:0]      r_vld;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [33:0] w_x;
        logic signed [33:0] w_y;
        logic signed [35:0] w_z;
        t_side              w_side;
        logic               w_vld;
        logic signed [35:0] w_at;

        if (k == 0) begin : g_first
            assign w_x    = CORDIC_GAIN_Q30;
            assign w_y    = '0;
            assign w_z    = i_z;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_y    = r_y[k-1];
            assign w_z    = r_z[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_at = $signed(ATAN_Q32[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                if (w_z >= 0) begin
                    r_x[k] <= w_x - (w_y >>> k);
                    r_y[k] <= w_y + (w_x >>> k);
                    r_z[k] <= w_z - w_at;
                end else begin
                    r_x[k] <= w_x + (w_y >>> k);
                    r_y[k] <= w_y - (w_x >>> k);
                    r_z[k] <= w_z + w_at;
                end
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_x    = r_x[NS-1];
    assign o_y    = r_y[NS-1];
    assign o_side = r_side[NS-1];

endmodule

### hw/rtl/affine_2d_transform_matrix_unit.sv
// 2D affine matrix from position, origin, scale and rotation. One request is
// taken per clock while the output is not stalled. Registers: three for angle
// reduction, one per CORDIC stage, five for the sign fix, products, rounding
// and the translation sum. Stalling the output freezes the whole pipeline in place.
`include "affine_2d_transform_matrix_unit_defines.svh"

module affine_2d_transform_matrix_unit #(
    parameter int CORDIC_STAGES = aff2d_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [23:0] i_scale_x,
    input  logic [23:0] i_scale_y,
    input  logic [23:0] i_angle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_m_sx_cos,
    output logic [23:0] o_m_sy_sin,
    output logic [23:0] o_m_neg_sx_sin,
    output logic [23:0] o_m_sy_cos,
    output logic [31:0] o_trans_x,
    output logic [31:0] o_trans_y
);
    import aff2d_pkg::*;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: quotient estimate
    logic               r1_vld;
    t_side              r1_side;
    logic [23:0]        r1_ang;
    logic signed [46:0] r1_prod;
    // stage 2: remainder in [0, 2pi)
    logic               r2_vld;
    t_side              r2_side;
    logic signed [35:0] r2_r;
    // stage 3: folded to [-pi/2, pi/2]
    logic               r3_vld;
    t_side              r3_side;
    logic signed [35:0] r3_z;
    // cordic out
    logic               w_c_vld;
    logic signed [33:0] w_c_x;
    logic signed [33:0] w_c_y;
    t_side              w_c_side;
    // stage 4..7
    logic               r4_vld;
    t_side              r4_side;
    logic signed [31:0] r4_cs;
    logic signed [31:0] r4_sn;
    logic               r5_vld;
    t_side              r5_side;
    logic signed [55:0] r5_pa, r5_pb, r5_pc, r5_pd;
    logic               r6_vld;
    t_side              r6_side;
    logic signed [25:0] r6_a, r6_b, r6_c, r6_d;
    logic               r7_vld;
    logic [31:0]        r7_px, r7_py;
    logic [23:0]        r7_ma, r7_mb, r7_mnc, r7_md;
    logic signed [57:0] r7_ta, r7_tb, r7_tc, r7_td;

    t_side w_in_side;
    assign w_in_side = '{px: i_pos_x, py: i_pos_y, ox: i_origin_x, oy: i_origin_y,
                         sx: i_scale_x, sy: i_scale_y, neg: 1'b0};

    // reduction arithmetic
    logic signed [6:0]  w_q;
    logic signed [42:0] w_qk, w_a, w_d, w_c;
    logic signed [35:0] w_r, w_f;
    logic               w_neg;

    always_comb begin
        w_q  = r1_prod[46:40];
        w_qk = w_q * ANG_TWO_PI;
        w_a  = $signed({{3{r1_ang[23]}}, r1_ang, 16'b0});
        w_d  = w_a - w_qk;
        if (w_d < 0) begin
            w_c = w_d + ANG_TWO_PI;
        end else if (w_d >= ANG_TWO_PI) begin
            w_c = w_d - ANG_TWO_PI;
        end else begin
            w_c = w_d;
        end
    end

    always_comb begin
        w_r   = (r2_r >= ANG_PI) ? r2_r - ANG_TWO_PI : r2_r;
        w_neg = 1'b0;
        w_f   = w_r;
        if (w_r > ANG_HALF_PI) begin
            w_f   = w_r - ANG_PI;
            w_neg = 1'b1;
        end else if (w_r < -ANG_HALF_PI) begin
            w_f   = w_r + ANG_PI;
            w_neg = 1'b1;
        end
    end

    t_side w_r3_side_n;
    always_comb begin
        w_r3_side_n     = r2_side;
        w_r3_side_n.neg = w_neg;
    end

    aff2d_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r3_vld),
        .i_z     (r3_z),
        .i_side  (r3_side),
        .o_vld   (w_c_vld),
        .o_x     (w_c_x),
        .o_y     (w_c_y),
        .o_side  (w_c_side)
    );

    logic signed [33:0] w_cs, w_sn;
    assign w_cs = w_c_side.neg ? -w_c_x : w_c_x;
    assign w_sn = w_c_side.neg ? -w_c_y : w_c_y;

    logic signed [55:0] w_ra, w_rb, w_rc, w_rd;
    assign w_ra = r5_pa + 56'sd536870912;
    assign w_rb = r5_pb + 56'sd536870912;
    assign w_rc = r5_pc + 56'sd536870912;
    assign w_rd = r5_pd + 56'sd536870912;

    logic signed [26:0] w_nc;
    assign w_nc = -$signed({r6_c[25], r6_c});

    logic signed [59:0] w_tx, w_ty;
    assign w_tx = -$signed({{2{r7_ta[57]}}, r7_ta}) - r7_tb
                  + $signed({{12{r7_px[31]}}, r7_px, 16'b0}) + 60'sd32768;
    assign w_ty = r7_tc - r7_td
                  + $signed({{12{r7_py[31]}}, r7_py, 16'b0}) + 60'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= w_c_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            o_valid <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side <= w_in_side;
            r1_ang  <= i_angle;
            r1_prod <= $signed(i_angle) * TWO_PI_RECIP;

            r2_side <= r1_side;
            r2_r    <= w_c[35:0];

            r3_side <= w_r3_side_n;
            r3_z    <= w_f;

            r4_side <= w_c_side;
            r4_cs   <= w_cs[31:0];
            r4_sn   <= w_sn[31:0];

            r5_side <= r4_side;
            r5_pa   <= $signed(r4_side.sx) * r4_cs;
            r5_pb   <= $signed(r4_side.sy) * r4_sn;
            r5_pc   <= $signed(r4_side.sx) * r4_sn;
            r5_pd   <= $signed(r4_side.sy) * r4_cs;

            r6_side <= r5_side;
            r6_a    <= w_ra[55:30];
            r6_b    <= w_rb[55:30];
            r6_c    <= w_rc[55:30];
            r6_d    <= w_rd[55:30];

            r7_px   <= r6_side.px;
            r7_py   <= r6_side.py;
            r7_ma   <= sat24({r6_a[25], r6_a});
            r7_mb   <= sat24({r6_b[25], r6_b});
            r7_mnc  <= sat24(w_nc);
            r7_md   <= sat24({r6_d[25], r6_d});
            r7_ta   <= $signed(r6_side.ox) * r6_a;
            r7_tb   <= $signed(r6_side.oy) * r6_b;
            r7_tc   <= $signed(r6_side.ox) * r6_c;
            r7_td   <= $signed(r6_side.oy) * r6_d;

            o_m_sx_cos     <= r7_ma;
            o_m_sy_sin     <= r7_mb;
            o_m_neg_sx_sin <= r7_mnc;
            o_m_sy_cos     <= r7_md;
            o_trans_x      <= sat32(w_tx[59:16]);
            o_trans_y      <= sat32(w_ty[59:16]);
        end
    end

    `AFF2D_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !o_valid)
    `AFF2D_ASSERT(a_fold_range, r3_vld |-> (r3_z <= ANG_HALF_PI && r3_z >= -ANG_HALF_PI))
    `AFF2D_ASSERT(a_frozen, o_stall |=> $stable({r1_vld, r2_vld, r3_vld, r4_vld, r7_vld}))

endmodule

### tb/sv/tb_affine_2d_transform_matrix_unit.sv
module tb_affine_2d_transform_matrix_unit;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint TWO_PI = 64'sd26986075409;
    localparam longint PI_Q32 = 64'sd13493037705;
    localparam longint HALF_PI = 64'sd6746518852;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct {
        logic [31:0] px, py, ox, oy;
        logic [23:0] sx, sy, ang;
    } xform_t;

    typedef struct {
        logic [23:0] sx_cos, sy_sin, neg_sx_sin, sy_cos;
        logic [31:0] tx, ty;
    } matrix_t;

    class matrix_scoreboard;
        matrix_t pending[$];
        int errors = 0;
        int checked = 0;

        function longint asr(longint v, int n);
            return v >>> n;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint rnd30(longint v);
            return (v + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function matrix_t compute(xform_t t);
            longint px, py, ox, oy, sx, sy, r, x, y, dx, dy, cs, sn, a, b, c, d, tx, ty;
            longint atan_tab[24];
            bit flip;
            matrix_t m;
            atan_tab = '{64'sd3373259426, 1991351318, 1052175346, 534100635, 268086715,
                         134174062, 67103403, 33553749, 16777131, 8388597, 4194303,
                         2097152, 1048576, 524288, 262144, 131072, 65536, 32768,
                         16384, 8192, 4096, 2048, 1024, 512};
            px = longint'($signed(t.px));
            py = longint'($signed(t.py));
            ox = longint'($signed(t.ox));
            oy = longint'($signed(t.oy));
            sx = longint'($signed(t.sx));
            sy = longint'($signed(t.sy));
            r = (longint'($signed(t.ang)) * 65536) % TWO_PI;
            flip = 0;
            if (r < 0) r += TWO_PI;
            if (r >= PI_Q32) r -= TWO_PI;
            if (r > HALF_PI) begin
                r -= PI_Q32;
                flip = 1;
            end else if (r < -HALF_PI) begin
                r += PI_Q32;
                flip = 1;
            end
            x = GAIN_Q30;
            y = 0;
            for (int i = 0; i < STAGES; i++) begin
                dx = asr(y, i);
                dy = asr(x, i);
                if (r >= 0) begin
                    x -= dx; y += dy; r -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; r += atan_tab[i];
                end
            end
            cs = flip ? -x : x;
            sn = flip ? -y : y;
            a = rnd30(sx * cs);
            b = rnd30(sy * sn);
            c = rnd30(sx * sn);
            d = rnd30(sy * cs);
            tx = (-(ox * a) - (oy * b) + px * 65536 + 32768) >>> 16;
            ty = ((ox * c) - (oy * d) + py * 65536 + 32768) >>> 16;
            m.sx_cos = 24'(clamp(a, 24));
            m.sy_sin = 24'(clamp(b, 24));
            m.neg_sx_sin = 24'(clamp(-c, 24));
            m.sy_cos = 24'(clamp(d, 24));
            m.tx = 32'(clamp(tx, 32));
            m.ty = 32'(clamp(ty, 32));
            return m;
        endfunction

        function void note_request(xform_t t);
            pending.push_back(compute(t));
        endfunction

        function void check_result(matrix_t got);
            matrix_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result, nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.sx_cos !== e.sx_cos) begin
                $error("m_sx_cos exp %h got %h", e.sx_cos, got.sx_cos); errors++;
            end
            if (got.sy_sin !== e.sy_sin) begin
                $error("m_sy_sin exp %h got %h", e.sy_sin, got.sy_sin); errors++;
            end
            if (got.neg_sx_sin !== e.neg_sx_sin) begin
                $error("m_neg_sx_sin exp %h got %h", e.neg_sx_sin, got.neg_sx_sin); errors++;
            end
            if (got.sy_cos !== e.sy_cos) begin
                $error("m_sy_cos exp %h got %h", e.sy_cos, got.sy_cos); errors++;
            end
            if (got.tx !== e.tx) begin
                $error("trans_x exp %h got %h", e.tx, got.tx); errors++;
            end
            if (got.ty !== e.ty) begin
                $error("trans_y exp %h got %h", e.ty, got.ty); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic o_stall, o_valid;
    logic [31:0] i_pos_x = 0, i_pos_y = 0, i_origin_x = 0, i_origin_y = 0;
    logic [23:0] i_scale_x = 0, i_scale_y = 0, i_angle = 0;
    logic [23:0] o_m_sx_cos, o_m_sy_sin, o_m_neg_sx_sin, o_m_sy_cos;
    logic [31:0] o_trans_x, o_trans_y;

    matrix_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int sent = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    affine_2d_transform_matrix_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

    // accept and result monitor and watchdog
    always @(posedge i_clk) begin
        matrix_t got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_request('{i_pos_x, i_pos_y, i_origin_x, i_origin_y,
                                     i_scale_x, i_scale_y, i_angle});
                sent++;
            end
            if (o_valid && !i_stall) begin
                got = '{o_m_sx_cos, o_m_sy_sin, o_m_neg_sx_sin, o_m_sy_cos,
                        o_trans_x, o_trans_y};
                board.check_result(got);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d pending", board.pending.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_xform(xform_t t);
        while (($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_pos_x, i_pos_y, i_origin_x, i_origin_y} <= {t.px, t.py, t.ox, t.oy};
        {i_scale_x, i_scale_y, i_angle} <= {t.sx, t.sy, t.ang};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick24();
        case ($urandom_range(5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 262143)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
            default: return $urandom;
        endcase
    endfunction

    function automatic xform_t random_xform();
        xform_t t;
        t = '{pick32(), pick32(), pick32(), pick32(), pick24(), pick24(), pick24()};
        // angles near multiples of pi/16 from -pi/2 to pi/2, including the fold boundaries
        if ($urandom_range(3) == 0)
            t.ang = 24'($signed($urandom_range(0, 16)) * 25736 / 2 - 102944
                        + $signed($urandom_range(0, 4)) - 2);
        return t;
    endfunction

    task automatic random_phase(int n, int idle, int stl);
        send_idle_pct = idle;
        recv_stall_pct = stl;
        repeat (n) send_xform(random_xform());
        drain();
    endtask

    initial begin
        logic [23:0] angs[10];
        angs = '{24'h000000, 24'h7fffff, 24'h800000, 24'h019220, 24'hfe6de0,
                 24'h03243f, 24'h03243e, 24'h06487f, 24'h01921f, 24'h00c910};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: field extremes, fold boundaries, saturation
        foreach (angs[k]) begin
            send_xform('{32'h00010000, 32'hffff0000, 32'h00008000, 32'h7fffffff,
                         24'h7fffff, 24'h800000, angs[k]});
        end
        send_xform('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                     24'h7fffff, 24'h7fffff, 24'h000000});
        send_xform('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     24'h800000, 24'h800000, 24'h019220});
        send_xform('{32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0, 24'h0});
        send_xform('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     24'hffffff, 24'hffffff, 24'hffffff});
        send_xform('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                     24'h555555, 24'haaaaaa, 24'h555555});
        send_xform('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                     24'haaaaaa, 24'h555555, 24'haaaaaa});
        drain();

        random_phase(234, 0, 0);
        random_phase(160, 57, 0);
        random_phase(160, 0, 57);
        random_phase(160, 21, 21);

        // long hold-off on the receiver while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (LATENCY * 4) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(120, 0, 0);
        join
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("%0d transforms sent, %0d matrices checked across idle/stall phases",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
